>>> rtl/assert_macros.svh
// Assertion helpers used by lsh_emit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lsh_pkg.sv
package lsh_pkg;

	localparam int PIX_W     = 8;
	localparam int OUT_ROW_W = 12;
	localparam int OUT_COL_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHARPEN_GAIN = 2'd2;

	// One window column: top is two rows up, bot is the current row.
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} lsh_col_t;

	// One line-buffer entry: the two rows above the current one.
	typedef struct packed {
		logic [PIX_W-1:0] prev2;
		logic [PIX_W-1:0] prev;
	} lsh_lines_t;

	// Results of one input. Bit order of mask / val:
	// 0: (row_hi, col_a), 1: (row_hi, col_b), 2: (row_lo, col_a), 3: (row_lo, col_b)
	typedef struct packed {
		logic [3:0]                mask;
		logic [3:0][PIX_W-1:0]     val;
		logic [OUT_ROW_W-1:0]      row_hi;
		logic [OUT_ROW_W-1:0]      row_lo;
		logic [OUT_COL_W-1:0]      col_a;
		logic [OUT_COL_W-1:0]      col_b;
	} lsh_item_t;

endpackage

>>> rtl/laplacian_sharpen_3x3.sv
// Streaming 3x3 Laplacian sharpener for 8-bit grey pixels in raster order. One pixel is
// taken per clock when not stalled; an input at the last column or in the last row
// releases up to four output pixels (the bottom row leaves together with the row above
// it), and the input stalls for each extra output beyond the first, since the output
// register drains one transfer per clock while m_tready is high. Input is also held off
// after every configuration write and reset, while the line buffer read address settles.
// Each output trails its source pixel by one row and one column; results are registered
// in the window and stage 1, then in the output register. The line buffers are a single
// MAX_WIDTH x 16 memory with one write and one registered read port and need no clearing.
module laplacian_sharpen_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] pixel_out, [19:8] out_row, [29:20] out_col
	output logic        m_tlast,   // run_last
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_wdata
);
	import lsh_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WDW = (CW + 1 > 11) ? CW + 1 : 11;
	localparam int HDW = (RW + 1 > 13) ? RW + 1 : 13;

	// configuration
	logic [10:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic [3:0]  sharpen_gain_q;
	logic        cfg_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 11'd512;
			frame_height_q <= 13'd512;
			sharpen_gain_q <= 4'd1;
			cfg_hold_q     <= 1'b1;
		end else begin
			cfg_hold_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[10:0];
					REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
					REG_SHARPEN_GAIN: sharpen_gain_q <= cfg_wdata[3:0];
					default: ;
				endcase
			end
		end
	end

	// last column / row after clamping the frame size to 1..MAX
	logic [WDW-1:0] wx;
	logic [HDW-1:0] hx;
	logic [CW-1:0]  last_c;
	logic [RW-1:0]  last_r;

	always_comb begin
		wx = WDW'(frame_width_q);
		hx = HDW'(frame_height_q);
		if (wx == '0) begin
			last_c = '0;
		end else if (wx > WDW'(MAX_WIDTH)) begin
			last_c = CW'(MAX_WIDTH - 1);
		end else begin
			last_c = CW'(wx - WDW'(1));
		end
		if (hx == '0) begin
			last_r = '0;
		end else if (hx > HDW'(MAX_HEIGHT)) begin
			last_r = RW'(MAX_HEIGHT - 1);
		end else begin
			last_r = RW'(hx - HDW'(1));
		end
	end

	// raster counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] c_cur;
	logic [RW-1:0] r_cur;
	logic [CW-1:0] col_nxt;
	logic [RW-1:0] row_nxt;
	logic          at_last_col;
	logic          at_last_row;
	logic          accept;

	assign c_cur       = (col_q > last_c) ? last_c : col_q;
	assign r_cur       = (row_q > last_r) ? last_r : row_q;
	assign at_last_col = (c_cur == last_c);
	assign at_last_row = (r_cur == last_r);

	always_comb begin
		if (at_last_col) begin
			col_nxt = '0;
			row_nxt = at_last_row ? '0 : r_cur + RW'(1);
		end else begin
			col_nxt = c_cur + CW'(1);
			row_nxt = r_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// line buffers
	lsh_lines_t lines_rd;
	lsh_lines_t lines_wr;

	assign lines_wr = '{prev2: lines_rd.prev, prev: s_tdata};

	lsh_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk   (clk),
		.we    (accept),
		.waddr (c_cur),
		.wdata (lines_wr),
		.raddr (accept ? col_nxt : c_cur),
		.rdata (lines_rd)
	);

	// window: three column cells, the newest column enters at cell 2
	lsh_col_t win [3];
	lsh_col_t new_col;

	assign new_col = '{top: lines_rd.prev2, mid: lines_rd.prev, bot: s_tdata};

	for (genvar k = 0; k < 3; k++) begin : g_cell
		if (k == 2) begin : g_head
			lsh_col_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (accept),
				.col_in  (new_col),
				.col_out (win[k])
			);
		end else begin : g_body
			lsh_col_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (accept),
				.col_in  (win[k+1]),
				.col_out (win[k])
			);
		end
	end

	// stage 1: position of the item now in the window
	logic          valid_s1;
	logic [CW-1:0] c_s1;
	logic [RW-1:0] r_s1;
	logic          lcol_s1;
	logic          lrow_s1;
	logic          item_ready;

	assign s_tready = !cfg_hold_q && (!valid_s1 || item_ready);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1    <= c_cur;
			r_s1    <= r_cur;
			lcol_s1 <= at_last_col;
			lrow_s1 <= at_last_row;
		end
	end

	// sharpening of the window centre
	logic [9:0]        nb_sum;
	logic signed [10:0] lap;
	logic [7:0]        lap_c;
	logic [11:0]       prod;
	logic [12:0]       boosted;
	logic [7:0]        sharp;

	always_comb begin
		nb_sum  = 10'(win[1].top) + 10'(win[1].bot) + 10'(win[0].mid) + 10'(win[2].mid);
		lap     = $signed({1'b0, win[1].mid, 2'b00}) - $signed({1'b0, nb_sum});
		if (lap < 0) begin
			lap_c = '0;
		end else if (lap > 11'sd255) begin
			lap_c = 8'hFF;
		end else begin
			lap_c = lap[7:0];
		end
		prod    = 12'(lap_c) * 12'(sharpen_gain_q);
		boosted = 13'(win[1].mid) + 13'(prod);
		sharp   = (boosted > 13'd255) ? 8'hFF : boosted[7:0];
	end

	lsh_item_t item;
	logic      has_r1;
	logic      has_c1;
	logic      interior;

	always_comb begin
		has_r1      = (r_s1 != '0);
		has_c1      = (c_s1 != '0);
		interior    = (r_s1 >= RW'(2)) && (c_s1 >= CW'(2));
		item.mask   = {lrow_s1 && lcol_s1, lrow_s1 && has_c1, has_r1 && lcol_s1, has_r1 && has_c1};
		item.val[0] = interior ? sharp : win[1].mid;
		item.val[1] = win[2].mid;
		item.val[2] = win[1].bot;
		item.val[3] = win[2].bot;
		item.row_hi = OUT_ROW_W'(r_s1 - RW'(1));
		item.row_lo = OUT_ROW_W'(r_s1);
		item.col_a  = OUT_COL_W'(c_s1 - CW'(1));
		item.col_b  = OUT_COL_W'(c_s1);
	end

	lsh_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_ready (item_ready),
		.item       (item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

>>> rtl/lsh_col_cell.sv
module lsh_col_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  lsh_pkg::lsh_col_t col_in,
	output lsh_pkg::lsh_col_t col_out
);
	import lsh_pkg::*;

	lsh_col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

>>> rtl/lsh_line_buf.sv
module lsh_line_buf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  lsh_pkg::lsh_lines_t  wdata,
	input  logic [AW-1:0]        raddr,
	output lsh_pkg::lsh_lines_t  rdata
);
	import lsh_pkg::*;

	lsh_lines_t mem [DEPTH];
	lsh_lines_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first on an address collision (single-column frames)
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/lsh_emit.sv
`include "assert_macros.svh"

module lsh_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  lsh_pkg::lsh_item_t item,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,  // [7:0] pixel_out, [19:8] out_row, [29:20] out_col
	output logic               m_tlast   // run_last
);
	import lsh_pkg::*;

	logic [3:0]           mask_q;
	lsh_item_t            item_q;
	logic                 m_tvalid_q;
	logic [31:0]          tdata_q;
	logic                 last_q;

	logic [3:0]           sel;
	logic [3:0]           nxt_mask;
	logic                 emit;
	logic [PIX_W-1:0]     sel_val;
	logic [OUT_ROW_W-1:0] sel_row;
	logic [OUT_COL_W-1:0] sel_col;

	assign sel        = mask_q & (~mask_q + 4'd1);
	assign nxt_mask   = mask_q & ~sel;
	assign emit       = (mask_q != 4'd0) && (!m_tvalid_q || m_tready);
	assign item_ready = (mask_q == 4'd0) || (emit && (nxt_mask == 4'd0));

	always_comb begin
		case (sel)
			4'b0010: begin
				sel_val = item_q.val[1];
				sel_row = item_q.row_hi;
				sel_col = item_q.col_b;
			end
			4'b0100: begin
				sel_val = item_q.val[2];
				sel_row = item_q.row_lo;
				sel_col = item_q.col_a;
			end
			4'b1000: begin
				sel_val = item_q.val[3];
				sel_row = item_q.row_lo;
				sel_col = item_q.col_b;
			end
			default: begin
				sel_val = item_q.val[0];
				sel_row = item_q.row_hi;
				sel_col = item_q.col_a;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				mask_q <= item.mask;
			end else if (emit) begin
				mask_q <= nxt_mask;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		if (emit) begin
			tdata_q <= {2'b00, sel_col, sel_row, sel_val};
			last_q  <= (nxt_mask == 4'd0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = last_q;

	// a result that is not the last of its input leaves the rest pending
	`ASSERT_IMP(a_rest_pending, clk, arst_n, m_tvalid_q && !last_q, mask_q != 4'd0, "non-last result with nothing left")
	// pending work with a free output register never idles
	`ASSERT_NXT(a_no_bubble, clk, arst_n, (mask_q != 4'd0) && !m_tvalid_q, m_tvalid_q, "pending result not moved out")
	// each step of a multi-result input retires exactly one result
	`ASSERT_NXT(a_one_per_step, clk, arst_n, emit && !$onehot(mask_q), $countones(mask_q) == $countones($past(mask_q)) - 1, "result count did not drop by one")

endmodule

>>> test/tb_laplacian_sharpen_3x3.sv
`timescale 1ns / 1ps

module tb_laplacian_sharpen_3x3;
	import lsh_pkg::*;

	localparam int MAX_W       = 1024;
	localparam int MAX_H       = 4096;
	localparam int SETTLE      = 8;
	localparam int RAND_ITEMS  = 97;
	localparam int IDLE_PCT    = 22;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DIR_ROWS    = 32;

	// no register sits at this index; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

	// idx is ignored on pixel rows; val carries the pixel there
	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] val;
		logic                 typed;
		logic [PIX_W-1:0]     first_pix;
	} dir_row_t;

	typedef struct {
		logic [PIX_W-1:0]     pix;
		logic                 known;
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic                 last;
	} sharp_px_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;     // [7:0] pixel_in
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;          // [7:0] pixel_out, [19:8] out_row, [29:20] out_col
	logic                 m_tlast;          // run_last
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	// shadow of the block: line stores, window taps, position and registers
	logic [PIX_W-1:0]  line_up [MAX_W];
	logic [PIX_W-1:0]  line_up2 [MAX_W];
	logic [PIX_W-1:0]  tap [9];
	int unsigned       row_at;
	int unsigned       col_at;
	logic [10:0]       width_r;
	logic [12:0]       height_r;
	logic [3:0]        gain_r;

	// line store entries hold nothing until written; track what is defined
	bit                line_up_ok [MAX_W];
	bit                line_up2_ok [MAX_W];
	bit                tap_ok [9];

	sharp_px_t pending_pixels [$];
	int        errors = 0;
	int        cycles = 0;
	bit        calm = 1'b0;

	dir_row_t directed_rows [DIR_ROWS] = '{
		// zero size acts as 1x1: each pixel comes straight back
		'{ROW_CFG, REG_FRAME_WIDTH,  13'd0,    1'b0, 8'd0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 13'd0,    1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    1'b1, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd255,  1'b1, 8'd255},
		// 3x3 frame, bright centre saturates
		'{ROW_CFG, REG_FRAME_WIDTH,  13'd3,    1'b0, 8'd0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 13'd3,    1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd10,   1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd20,   1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd30,   1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd40,   1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd255,  1'b1, 8'd10},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd60,   1'b1, 8'd20},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd70,   1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd80,   1'b1, 8'd40},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd90,   1'b1, 8'd255},
		// top gain, small Laplacian: 10 + 15*8
		'{ROW_CFG, REG_SHARPEN_GAIN, 13'd15,   1'b0, 8'd0},
		'{ROW_CFG, REG_UNUSED,       13'h1FFF, 1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd8,    1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd8,    1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd8,    1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd8,    1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd10,   1'b1, 8'd8},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd8,    1'b1, 8'd8},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd8,    1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd8,    1'b1, 8'd8},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd8,    1'b1, 8'd130},
		// oversize dimensions saturate, first row gives nothing yet
		'{ROW_CFG, REG_SHARPEN_GAIN, 13'd0,    1'b0, 8'd0},
		'{ROW_CFG, REG_FRAME_WIDTH,  13'd2047, 1'b0, 8'd0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 13'h1FFF, 1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd255,  1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    1'b0, 8'd0},
		'{ROW_PIX, REG_FRAME_WIDTH,  13'd255,  1'b0, 8'd0}
	};

	laplacian_sharpen_3x3 #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int unsigned eff_dim(int unsigned v, int unsigned maxv);
		if (v == 0)
			return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	// advance the shadow by one pixel and return the pixels it releases
	function automatic int predict_sharpen(input logic [PIX_W-1:0] px,
			output sharp_px_t res [4]);
		int unsigned w, h, r, c, orow, ocol;
		bit          last_col, last_row;
		int          n, rs, cs, ctr, lap, v, k, t;

		w = eff_dim(width_r, MAX_W);
		h = eff_dim(height_r, MAX_H);
		r = (row_at >= h) ? h - 1 : row_at;
		c = (col_at >= w) ? w - 1 : col_at;
		last_col = (c == w - 1);
		last_row = (r == h - 1);
		n = 0;

		for (k = 0; k < 6; k++) begin
			tap[k]    = tap[k + 3];
			tap_ok[k] = tap_ok[k + 3];
		end
		tap[6] = line_up2[c];
		tap[7] = line_up[c];
		tap[8] = px;
		tap_ok[6] = line_up2_ok[c];
		tap_ok[7] = line_up_ok[c];
		tap_ok[8] = 1'b1;
		line_up2[c] = line_up[c];
		line_up[c] = px;
		line_up2_ok[c] = line_up_ok[c];
		line_up_ok[c] = 1'b1;

		// taps: 3*(2 - column_age) + row offset, column c-1 sits at 3..5, row r-1 at +1
		for (rs = 0; rs < 2; rs++) begin
			if (rs == 0 ? r < 1 : !last_row)
				continue;
			orow = (rs == 0) ? r - 1 : r;
			for (cs = 0; cs < 2; cs++) begin
				if (cs == 0 ? c < 1 : !last_col)
					continue;
				ocol = (cs == 0) ? c - 1 : c;
				if (rs == 0 && cs == 0 && r >= 2 && c >= 2) begin
					ctr = tap[4];
					lap = 4 * ctr - int'(tap[3]) - int'(tap[5]) - int'(tap[1]) - int'(tap[7]);
					if (lap < 0)
						lap = 0;
					if (lap > 255)
						lap = 255;
					v = ctr + int'(gain_r) * lap;
					res[n].pix   = (v > 255) ? 8'd255 : 8'(v);
					res[n].known = tap_ok[1] && tap_ok[3] && tap_ok[4] && tap_ok[5] &&
						tap_ok[7];
				end else begin
					t = (cs == 0 ? 3 : 6) + (rs == 0 ? 1 : 2);
					res[n].pix   = tap[t];
					res[n].known = tap_ok[t];
				end
				res[n].row  = OUT_ROW_W'(orow);
				res[n].col  = OUT_COL_W'(ocol);
				res[n].last = 1'b0;
				n++;
			end
		end
		if (n > 0)
			res[n - 1].last = 1'b1;

		if (last_col) begin
			col_at = 0;
			row_at = last_row ? 0 : r + 1;
		end else begin
			col_at = c + 1;
			row_at = r;
		end
		return n;
	endfunction

	task automatic report_err(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// cfg_we stays high over back-to-back writes; the next pixel drops it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		case (idx)
			REG_FRAME_WIDTH:  width_r  = val[10:0];
			REG_FRAME_HEIGHT: height_r = val;
			REG_SHARPEN_GAIN: gain_r   = val[3:0];
			default: ;
		endcase
	endtask

	task automatic push_pixel(input logic [PIX_W-1:0] px, input logic typed,
			input logic [PIX_W-1:0] first_pix);
		sharp_px_t res [4];
		int        n, i;

		cfg_we <= 1'b0;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		n = predict_sharpen(px, res);
		if (typed && n > 0) begin
			res[0].pix   = first_pix;
			res[0].known = 1'b1;
		end
		for (i = 0; i < n; i++)
			pending_pixels.push_back(res[i]);
		@(negedge clk);
	endtask

	// wait out every expected pixel plus the pipeline tail
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin : check_out
		sharp_px_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				report_err($sformatf("unexpected pixel %0d at (%0d,%0d)",
					m_tdata[7:0], m_tdata[19:8], m_tdata[29:20]));
			end else begin
				want = pending_pixels.pop_front();
				if (want.known && m_tdata[7:0] !== want.pix)
					report_err($sformatf("pixel at (%0d,%0d): got %0d want %0d",
						want.row, want.col, m_tdata[7:0], want.pix));
				if (m_tdata[19:8] !== want.row)
					report_err($sformatf("row: got %0d want %0d", m_tdata[19:8], want.row));
				if (m_tdata[29:20] !== want.col)
					report_err($sformatf("col: got %0d want %0d", m_tdata[29:20], want.col));
				if (m_tlast !== want.last)
					report_err($sformatf("tlast at (%0d,%0d): got %0b want %0b",
						want.row, want.col, m_tlast, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("laplacian_sharpen_3x3 test failed");
			$finish;
		end
	end

	initial begin : stim
		int unsigned          w, h, r, c, left, n, phase, sent;
		int                   i;
		logic [CFG_DAT_W-1:0] w_val, h_val, g_val;
		logic [PIX_W-1:0]     px;

		foreach (line_up[j]) begin
			line_up[j]     = '0;
			line_up2[j]    = '0;
			line_up_ok[j]  = 1'b0;
			line_up2_ok[j] = 1'b0;
		end
		foreach (tap[j]) begin
			tap[j]    = '0;
			tap_ok[j] = 1'b1;
		end
		row_at   = 0;
		col_at   = 0;
		width_r  = 11'd512;
		height_r = 13'd512;
		gain_r   = 4'd1;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				if (i == 0 || directed_rows[i - 1].kind != ROW_CFG)
					settle();
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				push_pixel(directed_rows[i].val[7:0], directed_rows[i].typed,
					directed_rows[i].first_pix);
			end
		end

		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			phase++;
			calm = (phase >= 2 && phase < 4);
			settle();

			case ($urandom_range(9))
				0: w_val = '0;
				1: w_val = 13'd1024;
				2: w_val = 13'($urandom_range(1025, 2047));
				default: w_val = 13'($urandom_range(1, 8));
			endcase
			case ($urandom_range(9))
				0: h_val = '0;
				1: h_val = 13'd4096;
				2: h_val = 13'($urandom_range(4097, 8191));
				default: h_val = 13'($urandom_range(1, 6));
			endcase
			g_val = 13'($urandom_range(0, 15));
			if (phase == 1 || $urandom_range(99) < 70)
				write_reg(REG_FRAME_WIDTH, w_val);
			if (phase == 1 || $urandom_range(99) < 70)
				write_reg(REG_FRAME_HEIGHT, h_val);
			if (phase == 1 || $urandom_range(99) < 70)
				write_reg(REG_SHARPEN_GAIN, g_val);
			if ($urandom_range(99) < 10)
				write_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));

			// mostly finish the current frame, sometimes break off partway
			w = eff_dim(width_r, MAX_W);
			h = eff_dim(height_r, MAX_H);
			r = (row_at >= h) ? h - 1 : row_at;
			c = (col_at >= w) ? w - 1 : col_at;
			left = (h - 1 - r) * w + (w - c);
			if ($urandom_range(99) < 75)
				n = left + ($urandom_range(1) ? w * h : 0);
			else
				n = $urandom_range(1, 2 * w);
			if (n > 40)
				n = 40;
			if (n > RAND_ITEMS - sent)
				n = RAND_ITEMS - sent;

			repeat (n) begin
				case ($urandom_range(9))
					0: px = 8'd0;
					1: px = 8'hFF;
					default: px = 8'($urandom_range(0, 255));
				endcase
				push_pixel(px, 1'b0, 8'd0);
			end
			sent += n;
		end

		settle();
		if (errors == 0)
			$display("laplacian_sharpen_3x3 test passed");
		else
			$display("laplacian_sharpen_3x3 test failed");
		$finish;
	end

endmodule
